/* rtl/core/tofu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofu_pkg
// Shared types, codes and helper functions of the tetrahedron orientation fixer.
// ----------------------------------------------------------------------------
package tofu_pkg;

    localparam int DEF_POINT_DEPTH = 4096;
    localparam int IDX_W = 12;
    localparam int PT_W = 48;
    localparam int TOL_W = 40;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DEGEN = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef struct packed {
        logic [3:0][IDX_W-1:0] idx;
        logic [3:0][PT_W-1:0] pts;
    } job_t;

    typedef enum logic {
        F_IDLE,
        F_FETCH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PREP,
        B_MAC,
        B_DECIDE
    } back_state_t;

    function automatic logic signed [15:0] pt_coord(input logic [PT_W-1:0] p,
                                                     input logic [1:0] axis);
        logic signed [15:0] r;
        case (axis)
            2'd0: r = p[15:0];
            2'd1: r = p[31:16];
            default: r = p[47:32];
        endcase
        return r;
    endfunction

    // Vertex taken at a position of one of the six candidate orders.
    function automatic logic [1:0] perm_vert(input logic [2:0] k, input logic [1:0] pos);
        logic [1:0] r;
        r = pos;
        if (pos != 2'd0) begin
            unique case (k)
                3'd0: r = pos;
                3'd1: r = (pos == 2'd1) ? 2'd1 : ((pos == 2'd2) ? 2'd3 : 2'd2);
                3'd2: r = (pos == 2'd1) ? 2'd2 : ((pos == 2'd2) ? 2'd1 : 2'd3);
                3'd3: r = (pos == 2'd1) ? 2'd2 : ((pos == 2'd2) ? 2'd3 : 2'd1);
                3'd4: r = (pos == 2'd1) ? 2'd3 : ((pos == 2'd2) ? 2'd1 : 2'd2);
                3'd5: r = (pos == 2'd1) ? 2'd3 : ((pos == 2'd2) ? 2'd2 : 2'd1);
                default: r = pos;
            endcase
        end
        return r;
    endfunction

    // Order position of corner j of test t: faces pqr, prs, qsr, psq, then volume.
    function automatic logic [1:0] face_pos(input logic [2:0] t, input logic [1:0] j);
        logic [1:0] r;
        unique case (t)
            3'd1: r = (j == 2'd0) ? 2'd0 : ((j == 2'd1) ? 2'd2 : 2'd3);
            3'd2: r = (j == 2'd0) ? 2'd1 : ((j == 2'd1) ? 2'd3 : 2'd2);
            3'd3: r = (j == 2'd0) ? 2'd0 : ((j == 2'd1) ? 2'd3 : 2'd1);
            default: r = j;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/tofu_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofu_queue
// Two-entry queue of fetched check requests between the front and the back.
// ----------------------------------------------------------------------------
module tofu_queue
    import tofu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t pop_data
);

    job_t ent_reg [2];
    logic wr_ptr_reg;
    logic rd_ptr_reg;
    logic [1:0] count_reg;

    assign full = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/tofu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofu_front
// Accepts requests, writes loaded points and fetches the four vertices of checks.
// ----------------------------------------------------------------------------
module tofu_front
    import tofu_pkg::*;
#(
    parameter int POINT_DEPTH = DEF_POINT_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic operation,
    input  logic [IDX_W-1:0] point_index,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    input  logic signed [15:0] coord_z,
    input  logic [IDX_W-1:0] vertex_a,
    input  logic [IDX_W-1:0] vertex_b,
    input  logic [IDX_W-1:0] vertex_c,
    input  logic [IDX_W-1:0] vertex_d,
    output logic push,
    output job_t push_data,
    input  logic q_full
);

    localparam int AW = $clog2(POINT_DEPTH);

    logic [PT_W-1:0] mem [POINT_DEPTH];
    logic [PT_W-1:0] rd_data_reg;
    logic rd_ok_reg;

    front_state_t state_reg, state_next;
    logic [2:0] fcnt_reg;
    logic [3:0][IDX_W-1:0] idx_reg;
    logic [3:0][PT_W-1:0] pts_reg;

    logic accept;
    logic wr_en;
    logic [IDX_W-1:0] rd_idx;
    logic rd_ok;

    assign accept = in_valid && in_ready;
    assign wr_en = accept && (operation == OP_LOAD) && (32'(point_index) < 32'(POINT_DEPTH));
    assign rd_idx = idx_reg[fcnt_reg[1:0]];
    assign rd_ok = 32'(rd_idx) < 32'(POINT_DEPTH);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept && (operation == OP_CHECK)) begin
                    state_next = F_FETCH;
                end
            end
            F_FETCH: begin
                if (fcnt_reg == 3'd5) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        push = 1'b0;
        unique case (state_reg)
            F_IDLE: in_ready = (operation == OP_LOAD) || !q_full;
            F_FETCH: push = (fcnt_reg == 3'd5);
            default: in_ready = 1'b0;
        endcase
    end

    assign push_data.idx = idx_reg;
    assign push_data.pts = pts_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= F_IDLE;
            fcnt_reg <= 3'd0;
        end
        else begin
            state_reg <= state_next;
            fcnt_reg <= (state_reg == F_FETCH) ? fcnt_reg + 3'd1 : 3'd0;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[AW'(point_index)] <= {coord_z, coord_y, coord_x};
        end
        rd_data_reg <= mem[AW'(rd_idx)];
        rd_ok_reg <= rd_ok;
        if (accept) begin
            idx_reg <= {vertex_d, vertex_c, vertex_b, vertex_a};
        end
        if ((state_reg == F_FETCH) && (fcnt_reg != 3'd0) && (fcnt_reg != 3'd5)) begin
            pts_reg[2'(fcnt_reg - 3'd1)] <= rd_ok_reg ? rd_data_reg : '0;
        end
    end

endmodule

/* rtl/core/tofu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofu_back
// Runs the face and volume tests of each order on one shared multiplier.
// ----------------------------------------------------------------------------
module tofu_back
    import tofu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic [TOL_W-1:0] tol,
    input  logic q_valid,
    input  job_t q_data,
    output logic pop,
    output logic out_valid,
    input  logic out_ready,
    output logic [IDX_W-1:0] order_first,
    output logic [IDX_W-1:0] order_second,
    output logic [IDX_W-1:0] order_third,
    output logic [IDX_W-1:0] order_fourth,
    output logic [1:0] status
);

    back_state_t state_reg, state_next;
    job_t job_reg;
    logic [2:0] k_reg;
    logic [2:0] test_reg;
    logic [3:0] mcnt_reg;
    logic signed [17:0] sum_reg [3];
    logic signed [16:0] u_reg [3];
    logic signed [16:0] v_reg [3];
    logic signed [19:0] w_reg [3];
    logic signed [34:0] n_reg [3];
    logic signed [34:0] acc_reg;
    logic signed [55:0] prod_reg;
    logic signed [57:0] dacc_reg;

    logic out_valid_reg;
    logic [3:0][IDX_W-1:0] ord_reg;
    logic [1:0] status_reg;

    logic [1:0] va, vb, vc, vs;
    logic signed [35:0] mul_a;
    logic signed [19:0] mul_b;
    logic signed [57:0] tol_s;
    logic done, adv_test, adv_order, out_free;
    logic [1:0] res_status;

    assign va = perm_vert(k_reg, face_pos(test_reg, 2'd0));
    assign vb = perm_vert(k_reg, face_pos(test_reg, 2'd1));
    assign vc = perm_vert(k_reg, face_pos(test_reg, 2'd2));
    assign vs = perm_vert(k_reg, 2'd3);
    assign tol_s = $signed({18'd0, tol});
    assign out_free = !out_valid_reg || out_ready;
    assign pop = (state_reg == B_IDLE) && q_valid;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (mcnt_reg)
            4'd0: begin mul_a = 36'(u_reg[1]); mul_b = 20'(v_reg[2]); end
            4'd1: begin mul_a = 36'(u_reg[2]); mul_b = 20'(v_reg[1]); end
            4'd2: begin mul_a = 36'(u_reg[2]); mul_b = 20'(v_reg[0]); end
            4'd3: begin mul_a = 36'(u_reg[0]); mul_b = 20'(v_reg[2]); end
            4'd4: begin mul_a = 36'(u_reg[0]); mul_b = 20'(v_reg[1]); end
            4'd5: begin mul_a = 36'(u_reg[1]); mul_b = 20'(v_reg[0]); end
            4'd6: begin mul_a = 36'(n_reg[0]); mul_b = w_reg[0]; end
            4'd7: begin mul_a = 36'(n_reg[1]); mul_b = w_reg[1]; end
            4'd8: begin mul_a = 36'(n_reg[2]); mul_b = w_reg[2]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        done = 1'b0;
        adv_test = 1'b0;
        adv_order = 1'b0;
        res_status = ST_OK;
        if (test_reg != 3'd4) begin
            if (dacc_reg > tol_s) begin
                adv_test = 1'b1;
            end
            else if (dacc_reg >= -tol_s) begin
                done = 1'b1;
                res_status = ST_DEGEN;
            end
            else begin
                adv_order = 1'b1;
            end
        end
        else if (dacc_reg >= 0) begin
            done = 1'b1;
        end
        else begin
            adv_order = 1'b1;
        end
        if (adv_order && (k_reg == 3'd5)) begin
            adv_order = 1'b0;
            done = 1'b1;
            res_status = ST_NONE;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (q_valid) state_next = B_PREP;
            B_PREP: state_next = B_MAC;
            B_MAC: if (mcnt_reg == 4'd9) state_next = B_DECIDE;
            B_DECIDE: begin
                if (done) begin
                    if (out_free) state_next = B_IDLE;
                end
                else begin
                    state_next = B_PREP;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= B_IDLE;
            out_valid_reg <= 1'b0;
            k_reg <= 3'd0;
            test_reg <= 3'd0;
            mcnt_reg <= 4'd0;
        end
        else begin
            state_reg <= state_next;
            if ((state_reg == B_DECIDE) && done && out_free) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            mcnt_reg <= (state_reg == B_MAC) ? mcnt_reg + 4'd1 : 4'd0;
            if (pop) begin
                k_reg <= 3'd0;
                test_reg <= 3'd0;
            end
            else if (state_reg == B_DECIDE) begin
                if (adv_test) begin
                    test_reg <= test_reg + 3'd1;
                end
                else if (adv_order) begin
                    test_reg <= 3'd0;
                    k_reg <= k_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (pop) begin
            job_reg <= q_data;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= 18'(pt_coord(q_data.pts[0], 2'(i)))
                            + 18'(pt_coord(q_data.pts[1], 2'(i)))
                            + 18'(pt_coord(q_data.pts[2], 2'(i)))
                            + 18'(pt_coord(q_data.pts[3], 2'(i)));
            end
        end
        if (state_reg == B_PREP) begin
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= 17'(pt_coord(job_reg.pts[vb], 2'(i)))
                          - 17'(pt_coord(job_reg.pts[va], 2'(i)));
                v_reg[i] <= 17'(pt_coord(job_reg.pts[vc], 2'(i)))
                          - 17'(pt_coord(job_reg.pts[va], 2'(i)));
                if (test_reg == 3'd4) begin
                    w_reg[i] <= 20'(pt_coord(job_reg.pts[vs], 2'(i)))
                              - 20'(pt_coord(job_reg.pts[va], 2'(i)));
                end
                else begin
                    w_reg[i] <= 20'(sum_reg[i])
                              - (20'(pt_coord(job_reg.pts[va], 2'(i))) <<< 2);
                end
            end
        end
        if (state_reg == B_MAC) begin
            prod_reg <= 56'(mul_a) * 56'(mul_b);
            case (mcnt_reg)
                4'd1, 4'd3, 4'd5: acc_reg <= 35'(prod_reg);
                4'd2: n_reg[0] <= acc_reg - 35'(prod_reg);
                4'd4: n_reg[1] <= acc_reg - 35'(prod_reg);
                4'd6: n_reg[2] <= acc_reg - 35'(prod_reg);
                4'd7: dacc_reg <= 58'(prod_reg);
                4'd8, 4'd9: dacc_reg <= dacc_reg + 58'(prod_reg);
                default: acc_reg <= acc_reg;
            endcase
        end
        if ((state_reg == B_DECIDE) && done && out_free) begin
            status_reg <= res_status;
            if (res_status == ST_OK) begin
                ord_reg[0] <= job_reg.idx[perm_vert(k_reg, 2'd0)];
                ord_reg[1] <= job_reg.idx[perm_vert(k_reg, 2'd1)];
                ord_reg[2] <= job_reg.idx[perm_vert(k_reg, 2'd2)];
                ord_reg[3] <= job_reg.idx[perm_vert(k_reg, 2'd3)];
            end
            else begin
                ord_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign order_first = ord_reg[0];
    assign order_second = ord_reg[1];
    assign order_third = ord_reg[2];
    assign order_fourth = ord_reg[3];
    assign status = status_reg;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == ST_OK || status_reg == ST_DEGEN
                           || status_reg == ST_NONE))
        else $error("Result carries an undefined status code.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (ord_reg == '0))
        else $error("Failed check carries a nonzero order.");

    a_mac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_MAC) |-> (mcnt_reg <= 4'd9 && k_reg <= 3'd5 && test_reg <= 3'd4))
        else $error("Test sequencer ran past its last step.");

endmodule

/* rtl/core/tetra_orientation_fixer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tetra_orientation_fixer_unit
// Keeps a store of mesh points and finds a valid vertex order for tetrahedra.
// ----------------------------------------------------------------------------
// A request on the in channel (in_valid/in_ready) either loads one point into
// the store or checks one tetrahedron. A load gives no result. A check gives
// one result on the out channel (out_valid/out_ready). The front fetches the
// four vertices and hands them to a two-entry queue. The back runs up to six
// orders of five tests each on the single shared multiplier.
// The user must write the plane tolerance register with cfg_we and cfg_wdata
// only while the unit is idle; the unit itself does not enforce this.
// Reset empties the queue, drops any pending result and sets the tolerance to
// one; the point store keeps its contents undefined until written. A stalled
// receiver holds the result register, the back then waits with the next
// finished result, and the queue and front keep accepting check requests
// until the queue is full, and load requests even then.
// ----------------------------------------------------------------------------
module tetra_orientation_fixer_unit
    import tofu_pkg::*;
#(
    parameter int POINT_DEPTH = DEF_POINT_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [TOL_W-1:0] cfg_wdata,
    input  logic in_valid,
    output logic in_ready,
    input  logic operation,
    input  logic [IDX_W-1:0] point_index,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    input  logic signed [15:0] coord_z,
    input  logic [IDX_W-1:0] vertex_a,
    input  logic [IDX_W-1:0] vertex_b,
    input  logic [IDX_W-1:0] vertex_c,
    input  logic [IDX_W-1:0] vertex_d,
    output logic out_valid,
    input  logic out_ready,
    output logic [IDX_W-1:0] order_first,
    output logic [IDX_W-1:0] order_second,
    output logic [IDX_W-1:0] order_third,
    output logic [IDX_W-1:0] order_fourth,
    output logic [1:0] status
);

    logic [TOL_W-1:0] tol_reg;
    logic push, q_full, q_valid, pop;
    job_t push_data, pop_data;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tol_reg <= TOL_W'(1);
        end
        else if (cfg_we) begin
            tol_reg <= cfg_wdata;
        end
    end

    tofu_front #(.POINT_DEPTH(POINT_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .point_index(point_index),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .vertex_a(vertex_a), .vertex_b(vertex_b),
        .vertex_c(vertex_c), .vertex_d(vertex_d),
        .push(push), .push_data(push_data), .q_full(q_full)
    );

    tofu_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_data(push_data), .full(q_full),
        .pop(pop), .not_empty(q_valid), .pop_data(pop_data)
    );

    tofu_back u_back (
        .clk(clk), .rst_n(rst_n), .tol(tol_reg),
        .q_valid(q_valid), .q_data(pop_data), .pop(pop),
        .out_valid(out_valid), .out_ready(out_ready),
        .order_first(order_first), .order_second(order_second),
        .order_third(order_third), .order_fourth(order_fourth),
        .status(status)
    );

endmodule
